[rtl/core/phb_pkg.sv]
// ----------------------------------------------------------------------------
// phb_pkg: shared constants and table builders for the Phong shading block
// Reset values of the configuration registers and the functions that fill the
// log2 and exp2 tables at elaboration.
// ----------------------------------------------------------------------------
package phb_pkg;

    localparam int TABLE_ADDR_BITS_DEF = 8;

    localparam logic [1:0] CFG_SPEC_RED   = 2'd0;
    localparam logic [1:0] CFG_SPEC_GREEN = 2'd1;
    localparam logic [1:0] CFG_SPEC_BLUE  = 2'd2;
    localparam logic [1:0] CFG_SHINE      = 2'd3;

    localparam logic [15:0] SPEC_RST  = 16'd58982;
    localparam logic [15:0] SHINE_RST = 16'd51;

    // power path classes
    localparam logic [1:0] PW_TABLE = 2'd0;
    localparam logic [1:0] PW_ONE   = 2'd1;
    localparam logic [1:0] PW_ZERO  = 2'd2;

    function automatic longint unsigned isqrt64(input longint unsigned a_in);
        longint unsigned a;
        longint unsigned res;
        longint unsigned bitv;
        a    = a_in;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > a) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (a >= res + bitv) begin
                a   = a - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // floor(65536*log2(1+i/2^b)) by repeated squaring
    function automatic logic [15:0] log_entry(input int i, input int b);
        longint unsigned y;
        logic [15:0]     frac;
        y    = (64'd1 << 30) + (longint'(i) << (30 - b));
        frac = '0;
        for (int it = 0; it < 16; it++) begin
            y    = (y * y) >> 30;
            frac = {frac[14:0], 1'b0};
            if (y >= (64'd1 << 31)) begin
                frac[0] = 1'b1;
                y       = y >> 1;
            end
        end
        return frac;
    endfunction

    // 2^(-i/2^b) in Q1.32 as a product of rounded square roots
    function automatic logic [32:0] exp_entry(input int i, input int b);
        longint unsigned roots [1:12];
        longint unsigned e;
        roots[1] = isqrt64(64'd1 << 63);
        for (int j = 2; j <= 12; j++) roots[j] = isqrt64(roots[j-1] << 32);
        e = 64'd1 << 32;
        for (int j = 1; j <= b; j++)
            if (((i >> (b - j)) & 1) != 0)
                e = (e * roots[j] + (64'd1 << 31)) >> 32;
        return e[32:0];
    endfunction

endpackage

[rtl/core/phong_brdf_shade.sv]
// ----------------------------------------------------------------------------
// phong_brdf_shade: Phong specular plus diffuse shading, one query per item
// Reflects light about the normal, raises the clamped cosine to the shine
// exponent through log2/exp2 tables and adds the scaled specular colour.
// ----------------------------------------------------------------------------
//  channel | handshake                    | payload
//  in      | i_in_valid / o_in_ready      | view, light, normal xyz, diffuse rgb
//  out     | o_out_valid / i_out_ready    | out_red, out_green, out_blue
//  cfg     | i_cfg_we (no wait)           | i_cfg_idx, i_cfg_data
//
// Eight register stages; one item per clock while the output is not stalled.
// Depth is set by the component products, the dot products, the n.l*n.v
// product, the cosine clamp, the log lookup, the exponent multiply, the exp lookup and the colour multiply.
// Each stage holds while full and the next stage cannot take its item, so
// bubbles close up under a stall. Reset (synchronous) clears valid bits and
// reloads the configuration registers.
module phong_brdf_shade
    import phb_pkg::*;
#(
    parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [15:0] i_view_x,
    input  logic signed [15:0] i_view_y,
    input  logic signed [15:0] i_view_z,
    input  logic signed [15:0] i_light_x,
    input  logic signed [15:0] i_light_y,
    input  logic signed [15:0] i_light_z,
    input  logic signed [15:0] i_norm_x,
    input  logic signed [15:0] i_norm_y,
    input  logic signed [15:0] i_norm_z,
    input  logic [15:0]        i_diff_red,
    input  logic [15:0]        i_diff_green,
    input  logic [15:0]        i_diff_blue,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [16:0]        o_out_red,
    output logic [16:0]        o_out_green,
    output logic [16:0]        o_out_blue
);

    localparam int NS  = 8;
    localparam int TBL = 1 << TABLE_ADDR_BITS;

    typedef logic [15:0] t_rgb16 [3];

    // constant tables
    logic [15:0] w_log [TBL];
    logic [32:0] w_exp [TBL];
    for (genvar g = 0; g < TBL; g++) begin : g_rom
        localparam logic [15:0] LV = log_entry(g, TABLE_ADDR_BITS);
        localparam logic [32:0] EV = exp_entry(g, TABLE_ADDR_BITS);
        assign w_log[g] = LV;
        assign w_exp[g] = EV;
    end

    // configuration
    logic [15:0] r_spec [3];
    logic [15:0] r_shine;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spec[0] <= SPEC_RST;
            r_spec[1] <= SPEC_RST;
            r_spec[2] <= SPEC_RST;
            r_shine   <= SHINE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SPEC_RED:   r_spec[0] <= i_cfg_data;
                CFG_SPEC_GREEN: r_spec[1] <= i_cfg_data;
                CFG_SPEC_BLUE:  r_spec[2] <= i_cfg_data;
                CFG_SHINE:      r_shine   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage flow control
    logic [NS-1:0] r_vld;
    logic [NS-1:0] w_en;

    always_comb begin
        w_en[NS-1] = !r_vld[NS-1] || i_out_ready;
        for (int i = NS - 2; i >= 0; i--) w_en[i] = !r_vld[i] || w_en[i+1];
    end

    assign o_in_ready  = w_en[0];
    assign o_out_valid = r_vld[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) r_vld[0] <= i_in_valid;
            for (int i = 1; i < NS; i++)
                if (w_en[i]) r_vld[i] <= r_vld[i-1];
        end
    end

    // diffuse colour travels with the item
    t_rgb16 r_diff [NS-1];

    // stage 0: products
    logic signed [31:0] r0_lv [3];
    logic signed [31:0] r0_nl [3];
    logic signed [31:0] r0_nv [3];

    // stage 1: dot products
    logic signed [32:0] r1_lv;
    logic signed [19:0] r1_nl;
    logic signed [19:0] r1_nv;
    logic signed [33:0] n1_sl, n1_sv;
    logic signed [19:0] n1_nl, n1_nv;

    function automatic logic signed [19:0] rnd14(input logic signed [33:0] x);
        logic [33:0] a;
        logic [33:0] q;
        a = x[33] ? 34'(-x) : 34'(x);
        q = (a + 34'd8192) >> 14;
        return x[33] ? -20'(q) : 20'(q);
    endfunction

    always_comb begin
        n1_sl = 34'(r0_nl[0]) + 34'(r0_nl[1]) + 34'(r0_nl[2]);
        n1_sv = 34'(r0_nv[0]) + 34'(r0_nv[1]) + 34'(r0_nv[2]);
        n1_nl = rnd14(n1_sl);
        n1_nv = rnd14(n1_sv);
    end

    // stage 2: n.l * n.v
    logic signed [32:0] r2_lv;
    logic signed [39:0] r2_pr;

    // stage 3: cosine, Q1.16 clamped
    logic [16:0]        r3_c;
    logic signed [40:0] n3_rv;
    logic [40:0]        n3_t;
    logic [16:0]        n3_c;

    always_comb begin
        n3_rv = 41'(r2_lv) - (41'(r2_pr) <<< 1);
        n3_t  = (41'(n3_rv) + 41'd2048) >> 12;
        if (n3_rv <= 0)              n3_c = '0;
        else if (n3_t > 41'd65536)   n3_c = 17'd65536;
        else                         n3_c = n3_t[16:0];
    end

    // stage 4: -log2(c) in Q5.16
    logic [1:0]  r4_cls;
    logic [20:0] r4_lg;
    logic [1:0]  n4_cls;
    logic [3:0]  n4_lz;
    logic [15:0] n4_cn;
    logic [TABLE_ADDR_BITS-1:0] n4_addr;
    logic [20:0] n4_lg;

    always_comb begin
        n4_lz = 4'd15;
        for (int b = 0; b < 16; b++)
            if (r3_c[b]) n4_lz = 4'(15 - b);
        n4_cn   = r3_c[15:0] << n4_lz;
        n4_addr = n4_cn[14 -: TABLE_ADDR_BITS];
        n4_lg   = ({16'd0, 5'(n4_lz) + 5'd1} << 16) - 21'(w_log[n4_addr]);
        if (r_shine == '0 || r3_c[16]) n4_cls = PW_ONE;
        else if (r3_c == '0)           n4_cls = PW_ZERO;
        else                           n4_cls = PW_TABLE;
    end

    // stage 5: exponent product
    logic [1:0]  r5_cls;
    logic [28:0] r5_e;
    logic [36:0] n5_m;

    assign n5_m = (37'(r4_lg) * 37'(r_shine) + 37'd128) >> 8;

    // stage 6: power in Q1.16
    logic [16:0] r6_pw;
    logic [12:0] n6_k;
    logic [TABLE_ADDR_BITS-1:0] n6_addr;
    logic [5:0]  n6_sh;
    logic [32:0] n6_x;
    logic [33:0] n6_r;
    logic [16:0] n6_pw;

    always_comb begin
        n6_k    = r5_e[28:16];
        n6_addr = r5_e[15 -: TABLE_ADDR_BITS];
        n6_sh   = 6'(n6_k) + 6'd15;
        n6_x    = w_exp[n6_addr] >> n6_sh;
        n6_r    = (34'(n6_x) + 34'd1) >> 1;
        case (r5_cls)
            PW_ONE:  n6_pw = 17'd65536;
            PW_ZERO: n6_pw = '0;
            default: begin
                if (n6_k >= 13'd48)          n6_pw = '0;
                else if (n6_r > 34'd65536)   n6_pw = 17'd65536;
                else                         n6_pw = n6_r[16:0];
            end
        endcase
    end

    // stage 7: colour
    logic [16:0] r7_out [3];
    logic [16:0] n7_out [3];

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            logic [32:0] sp;
            logic [17:0] sum;
            sp  = (33'(r_spec[ch]) * 33'(r6_pw) + 33'd32768) >> 16;
            sum = 18'(sp) + 18'(r_diff[NS-2][ch]);
            n7_out[ch] = sum[17] ? 17'h1FFFF : sum[16:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r0_lv[0] <= i_light_x * i_view_x;
            r0_lv[1] <= i_light_y * i_view_y;
            r0_lv[2] <= i_light_z * i_view_z;
            r0_nl[0] <= i_norm_x * i_light_x;
            r0_nl[1] <= i_norm_y * i_light_y;
            r0_nl[2] <= i_norm_z * i_light_z;
            r0_nv[0] <= i_norm_x * i_view_x;
            r0_nv[1] <= i_norm_y * i_view_y;
            r0_nv[2] <= i_norm_z * i_view_z;
            r_diff[0][0] <= i_diff_red;
            r_diff[0][1] <= i_diff_green;
            r_diff[0][2] <= i_diff_blue;
        end
        for (int i = 1; i < NS - 1; i++)
            if (w_en[i]) r_diff[i] <= r_diff[i-1];
        if (w_en[1]) begin
            r1_lv <= 33'(r0_lv[0]) + 33'(r0_lv[1]) + 33'(r0_lv[2]);
            r1_nl <= n1_nl;
            r1_nv <= n1_nv;
        end
        if (w_en[2]) begin
            r2_lv <= r1_lv;
            r2_pr <= 40'(r1_nl) * 40'(r1_nv);
        end
        if (w_en[3]) r3_c <= n3_c;
        if (w_en[4]) begin
            r4_cls <= n4_cls;
            r4_lg  <= n4_lg;
        end
        if (w_en[5]) begin
            r5_cls <= r4_cls;
            r5_e   <= n5_m[28:0];
        end
        if (w_en[6]) r6_pw <= n6_pw;
        if (w_en[7]) r7_out <= n7_out;
    end

    assign o_out_red   = r7_out[0];
    assign o_out_green = r7_out[1];
    assign o_out_blue  = r7_out[2];

endmodule
